// File: rtl/edf_tick_scheduler_assert.svh
// Assertion macros for the EDF tick scheduler.
// Used by the top level; needs a clock and an active-low reset.
`ifndef EDF_TICK_SCHEDULER_ASSERT_SVH
`define EDF_TICK_SCHEDULER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define EDFTS_ASSERT_IMPLY(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("edf_tick_scheduler: assertion failed");

// Next-cycle implication, disabled during reset
`define EDFTS_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("edf_tick_scheduler: assertion failed");

`endif

// File: rtl/edfts_pkg.sv
// Shared types and constants for the EDF tick scheduler.
// No dependencies.
package edfts_pkg;

  localparam int unsigned FieldW    = 16;
  localparam int unsigned DefMaxTasks = 8;
  localparam int unsigned DefTimeW  = 16;

  // Command codes of an input word
  localparam logic CmdLoad = 1'b0;
  localparam logic CmdTick = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] RegTaskCount = 2'd0;
  localparam logic [1:0] RegHorizon   = 2'd1;
  localparam logic [1:0] RegStartTime = 2'd2;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic load;
    logic start;
    logic step;
    logic commit;
    logic found;
  } edfts_ctrl_t;

endpackage

// File: rtl/edfts_remdiv.sv
// Bit-serial restoring remainder unit, one dividend bit per step.
// Uses edfts_pkg for the divisor width.
module edfts_remdiv #(
  parameter int unsigned DW = 16
) (
  input  logic                        clk_i,
  input  logic                        start_i,
  input  logic                        step_i,
  input  logic [DW-1:0]               dividend_i,
  input  logic [edfts_pkg::FieldW-1:0] divisor_i,
  output logic [edfts_pkg::FieldW-1:0] rem_o
);
  import edfts_pkg::*;

  logic [DW-1:0]     dvd_q, dvd_d;
  logic [FieldW-1:0] rem_q, rem_d;
  logic [FieldW:0]   shifted;

  // Shift in one bit, subtract the divisor when it fits
  always_comb begin
    shifted = {rem_q, dvd_q[DW-1]};
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    if (start_i) begin
      dvd_d = dividend_i;
      rem_d = '0;
    end else if (step_i) begin
      dvd_d = dvd_q << 1;
      if (shifted >= {1'b0, divisor_i}) begin
        rem_d = FieldW'(shifted - {1'b0, divisor_i});
      end else begin
        rem_d = shifted[FieldW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign rem_o = rem_q;

endmodule

// File: rtl/edfts_cell.sv
// One task slot of the scheduler chain: task state, distance and
// period test, and one stage of the winner-selection token chain.
// Uses edfts_pkg and edfts_remdiv.
module edfts_cell #(
  parameter int unsigned TW  = 16,
  parameter int unsigned IW  = 3,
  parameter int unsigned IDX = 0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  edfts_pkg::edfts_ctrl_t       ctrl_i,
  input  logic [2:0]                   slot_i,
  input  logic [edfts_pkg::FieldW-1:0] exec_i,
  input  logic [edfts_pkg::FieldW-1:0] dl_i,
  input  logic [edfts_pkg::FieldW-1:0] per_i,
  input  logic [TW-1:0]                time_i,
  input  logic [3:0]                   count_i,
  input  logic [IW-1:0]                win_i,
  input  logic                         tok_found_i,
  input  logic [((TW > 16) ? TW : 16):0] tok_best_i,
  input  logic [IW-1:0]                tok_win_i,
  output logic                         tok_found_o,
  output logic [((TW > 16) ? TW : 16):0] tok_best_o,
  output logic [IW-1:0]                tok_win_o
);
  import edfts_pkg::*;

  localparam int unsigned W = (TW > 16) ? TW : 16;
  localparam logic [6:0] IdxV = 7'(IDX);

  logic [FieldW-1:0] exec_q, dl_q, per_q, cnt_q, cnt_d;
  logic              started_q, started_d;
  logic              tf_q;
  logic [W:0]        tb_q;
  logic [IW-1:0]     tw_q;
  logic [W-1:0]      t_ext, dl_ext, per_ext, back;
  logic [FieldW-1:0] rem_back, rem_time;
  logic [W:0]        gap;
  logic              clr, in_use, active, take, won, started_n;

  assign t_ext   = W'(time_i);
  assign dl_ext  = W'(dl_q);
  assign per_ext = W'(per_q);
  assign back    = t_ext - dl_ext;

  edfts_remdiv #(.DW(W)) u_rem_back (
    .clk_i, .start_i(ctrl_i.start), .step_i(ctrl_i.step),
    .dividend_i(back), .divisor_i(per_q), .rem_o(rem_back)
  );
  edfts_remdiv #(.DW(W)) u_rem_time (
    .clk_i, .start_i(ctrl_i.start), .step_i(ctrl_i.step),
    .dividend_i(t_ext), .divisor_i(per_q), .rem_o(rem_time)
  );

  // Distance to the next deadline, far when the deadline is past and the period is zero
  always_comb begin
    if (dl_ext > t_ext) begin
      gap = {1'b0, dl_ext - t_ext};
    end else if (per_q == '0) begin
      gap = '1;
    end else begin
      gap = (W+1)'(per_q - rem_back);
    end
  end

  assign clr = (t_ext == per_ext) ||
               ((per_q != '0) && (t_ext > per_ext) && (rem_time == '0));

  // Join the selection token
  assign in_use = (IdxV < {3'b000, count_i});
  assign active = in_use && (exec_q > cnt_q);
  always_comb begin
    take = 1'b0;
    if (active) begin
      if (!tok_found_i)            take = 1'b1;
      else if (gap == tok_best_i)  take = started_q;
      else if (gap < tok_best_i)   take = 1'b1;
    end
  end

  // Mark the winner, then drop tasks in use whose period boundary is now
  assign won       = ctrl_i.found && (win_i == IW'(IDX));
  assign started_n = started_q | won;
  always_comb begin
    started_d = started_q;
    cnt_d     = cnt_q;
    if (ctrl_i.load && ({4'b0000, slot_i} == IdxV)) begin
      started_d = 1'b0;
      cnt_d     = '0;
    end else if (ctrl_i.commit) begin
      if (started_n && clr && in_use) begin
        started_d = 1'b0;
        cnt_d     = '0;
      end else begin
        started_d = started_n;
        cnt_d     = cnt_q + FieldW'(won);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      cnt_q     <= '0;
      tf_q      <= 1'b0;
    end else begin
      started_q <= started_d;
      cnt_q     <= cnt_d;
      tf_q      <= take | tok_found_i;
    end
  end

  // Task parameters and token payload
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load && ({4'b0000, slot_i} == IdxV)) begin
      exec_q <= exec_i;
      dl_q   <= dl_i;
      per_q  <= per_i;
    end
    tb_q <= take ? gap : tok_best_i;
    tw_q <= take ? IW'(IDX) : tok_win_i;
  end

  assign tok_found_o = tf_q;
  assign tok_best_o  = tb_q;
  assign tok_win_o   = tw_q;

endmodule

// File: rtl/edf_tick_scheduler.sv
// Earliest-deadline-first tick scheduler over a chain of task cells.
// Uses edfts_pkg, edfts_cell, edfts_remdiv and the assertion header.
//
// A tick word runs the per-cell bit-serial remainder units over
// W = max(TIME_WIDTH, 16) dividend bits, then passes the selection token
// through the cell chain, then issues the result and updates the cells,
// waiting while the output register is still full. A tick at or beyond
// the horizon goes straight to issuing a done result. The result sits in an
// output register; a new word is taken while it waits.
`include "edf_tick_scheduler_assert.svh"
module edf_tick_scheduler #(
  parameter int unsigned MAX_TASKS  = edfts_pkg::DefMaxTasks,
  parameter int unsigned TIME_WIDTH = edfts_pkg::DefTimeW
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [2:0]  task_slot_i,
  input  logic [15:0] exec_time_i,
  input  logic [15:0] deadline_i,
  input  logic [15:0] period_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  task_index_o,
  output logic        idle_o,
  output logic        done_res_o
);
  import edfts_pkg::*;

  localparam int unsigned W  = (TIME_WIDTH > 16) ? TIME_WIDTH : 16;
  localparam int unsigned IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CMax = (W > MAX_TASKS) ? W : MAX_TASKS;
  localparam int unsigned CW = $clog2(CMax + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [TIME_WIDTH-1:0] time_q, time_d;
  logic [3:0]            tcount_q;
  logic [15:0]           horizon_q, start_q;
  logic                  done_q, done_d;
  logic                  ov_q;
  logic [2:0]            oidx_q;
  logic                  oidle_q, odone_q;
  logic                  in_acc, tick_acc, load_acc, out_free, fin_go;
  edfts_ctrl_t           ctrl;

  logic                  tf [MAX_TASKS+1];
  logic [W:0]            tb [MAX_TASKS+1];
  logic [IW-1:0]         tw [MAX_TASKS+1];

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign tick_acc   = in_acc && (cmd_i == CmdTick);
  assign load_acc   = in_acc && (cmd_i == CmdLoad);
  assign out_free   = !ov_q || out_ready_i;
  assign fin_go     = (state_q == ST_FIN) && out_free;

  // Broadcast control
  assign ctrl.load   = load_acc;
  assign ctrl.start  = tick_acc;
  assign ctrl.step   = (state_q == ST_DIV);
  assign ctrl.commit = fin_go && !done_q;
  assign ctrl.found  = fin_go && !done_q && tf[MAX_TASKS];

  // Sequence one tick: divide, scan, finish
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = done_q;
    unique case (state_q)
      ST_IDLE: begin
        if (tick_acc) begin
          done_d = (W'(time_q) >= W'(horizon_q));
          cnt_d  = '0;
          state_d = done_d ? ST_FIN : ST_DIV;
        end
      end
      ST_DIV: begin
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(W - 1)) begin
          cnt_d   = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(MAX_TASKS - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Time: set by a load in range, advance after a scheduled tick
  always_comb begin
    time_d = time_q;
    if (load_acc && ({4'b0000, task_slot_i} < 7'(MAX_TASKS))) begin
      time_d = TIME_WIDTH'(start_q);
    end else if (ctrl.commit) begin
      time_d = time_q + TIME_WIDTH'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      done_q    <= 1'b0;
      time_q    <= TIME_WIDTH'(1);
      tcount_q  <= 4'd1;
      horizon_q <= 16'hFFFF;
      start_q   <= 16'd1;
      ov_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
      time_q  <= time_d;
      if (fin_go)                   ov_q <= 1'b1;
      else if (out_ready_i)         ov_q <= 1'b0;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          RegTaskCount: tcount_q  <= cfg_data_i[3:0];
          RegHorizon:   horizon_q <= cfg_data_i;
          RegStartTime: start_q   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Output word register
  always_ff @(posedge clk_i) begin
    if (fin_go) begin
      odone_q <= done_q;
      oidle_q <= !done_q && !tf[MAX_TASKS];
      oidx_q  <= (!done_q && tf[MAX_TASKS]) ? 3'(tw[MAX_TASKS]) : 3'd0;
    end
  end

  assign cfg_ready_o  = 1'b1;
  assign out_valid_o  = ov_q;
  assign task_index_o = oidx_q;
  assign idle_o       = oidle_q;
  assign done_res_o   = odone_q;

  // Token chain seed
  assign tf[0] = 1'b0;
  assign tb[0] = '0;
  assign tw[0] = '0;

  for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
    edfts_cell #(.TW(TIME_WIDTH), .IW(IW), .IDX(g)) u_cell (
      .clk_i, .rst_ni, .ctrl_i(ctrl), .slot_i(task_slot_i),
      .exec_i(exec_time_i), .dl_i(deadline_i), .per_i(period_i),
      .time_i(time_q), .count_i(tcount_q), .win_i(tw[MAX_TASKS]),
      .tok_found_i(tf[g]), .tok_best_i(tb[g]), .tok_win_i(tw[g]),
      .tok_found_o(tf[g+1]), .tok_best_o(tb[g+1]), .tok_win_o(tw[g+1])
    );
  end

  `EDFTS_ASSERT_IMPLY(a_busy_no_accept, clk_i, rst_ni, state_q != ST_IDLE, !in_ready_o)
  `EDFTS_ASSERT_IMPLY(a_done_excl, clk_i, rst_ni, out_valid_o, !(idle_o && done_res_o))
  `EDFTS_ASSERT_NEXT(a_fin_idle, clk_i, rst_ni, fin_go, state_q == ST_IDLE && out_valid_o)
  `EDFTS_ASSERT_IMPLY(a_commit_in_fin, clk_i, rst_ni, ctrl.commit, state_q == ST_FIN && !done_q)

endmodule
